// ===== hdl/lru_residency_size_budget_macros.svh =====
// assertion macros for the lru residency tracker
// included by the module that carries concurrent assertions; no other dependencies
`ifndef LRU_RESIDENCY_SIZE_BUDGET_MACROS_SVH
`define LRU_RESIDENCY_SIZE_BUDGET_MACROS_SVH

`ifndef SYNTH

// expression holds at every clock edge out of reset
`define LRB_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LRB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define LRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LRB_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define LRB_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define LRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/lrb_pkg.sv =====
// shared constants, types and helpers of the lru residency tracker
// no dependencies
package lrb_pkg;

    localparam int NUM_ENTRIES = 32;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int IN_IDX_W    = 5;
    localparam int SIZE_W      = 16;
    localparam int USED_W      = 21;
    localparam int RED_STEPS   = ((1 << IN_IDX_W) - 1) / NUM_ENTRIES;

    localparam logic [USED_W-1:0] USED_MAX     = {USED_W{1'b1}};
    localparam logic [USED_W-1:0] BUDGET_RESET = {USED_W{1'b1}};

    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic [1:0] {
        EV_HIT   = 2'd0,
        EV_MISS  = 2'd1,
        EV_EVICT = 2'd2,
        EV_FLUSH = 2'd3
    } t_event;

    typedef struct packed {
        t_event              event_res;
        logic [IN_IDX_W-1:0] result_index;
        logic [USED_W-1:0]   used_total;
        logic                last;
    } t_out_item;

    // write command into the list store: prev field and the next/size word
    typedef struct packed {
        logic              prev_we;
        t_idx              prev_addr;
        t_idx              prev_data;
        logic              next_we;
        logic              size_we;
        t_idx              link_addr;
        t_idx              next_data;
        logic [SIZE_W-1:0] size_data;
    } t_wr_cmd;

    typedef struct packed {
        t_idx              prev;
        t_idx              next;
        logic [SIZE_W-1:0] size;
    } t_rd_data;

    // entry number mod NUM_ENTRIES: RED_STEPS subtracts, then truncation
    function automatic t_idx reduce_index(logic [IN_IDX_W-1:0] v);
        logic [IN_IDX_W:0] t;
        t = {1'b0, v};
        for (int k = 0; k < RED_STEPS; k++) begin
            if (t >= (IN_IDX_W + 1)'(NUM_ENTRIES)) begin
                t = t - (IN_IDX_W + 1)'(NUM_ENTRIES);
            end
        end
        return IDX_W'(t);
    endfunction

endpackage

// ===== hdl/lrb_ifs.sv =====
// valid/ready channel interfaces for lookup requests and result items
// depends on lrb_pkg
interface lrb_in_if;
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [lrb_pkg::IN_IDX_W-1:0]        entry_index;
    logic [lrb_pkg::SIZE_W-1:0]          entry_size;

    modport source (output valid, output mode, output entry_index, output entry_size,
                    input ready);
    modport sink   (input valid, input mode, input entry_index, input entry_size,
                    output ready);
endinterface

interface lrb_out_if;
    logic                                valid;
    logic                                ready;
    lrb_pkg::t_event                     event_res;
    logic [lrb_pkg::IN_IDX_W-1:0]        result_index;
    logic [lrb_pkg::USED_W-1:0]          used_total;
    logic                                last;

    modport source (output valid, output event_res, output result_index, output used_total,
                    output last, input ready);
    modport sink   (input valid, input event_res, input result_index, input used_total,
                    input last, output ready);
endinterface

// ===== hdl/lrb_list_store.sv =====
// linked-list store: prev link memory and next link / size memory, one read port
// depends on lrb_pkg
module lrb_list_store (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  lrb_pkg::t_idx     i_rd_addr,
    input  lrb_pkg::t_wr_cmd  i_wr,
    output lrb_pkg::t_rd_data o_rd
);

    lrb_pkg::t_idx               r_prev_mem [lrb_pkg::NUM_ENTRIES];
    lrb_pkg::t_idx               r_next_mem [lrb_pkg::NUM_ENTRIES];
    logic [lrb_pkg::SIZE_W-1:0]  r_size_mem [lrb_pkg::NUM_ENTRIES];
    lrb_pkg::t_rd_data           r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.prev_we) begin
            r_prev_mem[i_wr.prev_addr] <= i_wr.prev_data;
        end
        // next and size share one word, written under field enables
        if (i_wr.next_we) begin
            r_next_mem[i_wr.link_addr] <= i_wr.next_data;
        end
        if (i_wr.size_we) begin
            r_size_mem[i_wr.link_addr] <= i_wr.size_data;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd.prev <= r_prev_mem[i_rd_addr];
            r_rd.next <= r_next_mem[i_rd_addr];
            r_rd.size <= r_size_mem[i_rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule

// ===== hdl/lru_residency_size_budget.sv =====
// Residency tracker that keeps up to NUM_ENTRIES numbered entries in least-recently-used
// order under a budget of chunks. The order is a doubly linked list (head = most recent,
// tail = least recent) in a store with a registered read; resident bits, count, used total,
// head and tail are flip-flops. A hit on the front entry leaves the order unchanged, any
// other hit moves the entry to the head, a miss first evicts from the tail while the total
// is over budget and then loads the entry at the head, and a flush evicts every resident
// entry in ascending index order. Each eviction reads the entry's link and size from the
// list store, then emits its result and updates the state. Results sit in an output register,
// so the block runs on while a result waits to be taken, up to its next result. The budget
// register is written with i_cfg_we and is meant to change only while the block is idle.
// depends on lrb_pkg, lrb_ifs, lrb_list_store and the assertion macro header
`include "lru_residency_size_budget_macros.svh"

module lru_residency_size_budget (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lrb_pkg::USED_W-1:0]   i_cfg_wdata,
    lrb_in_if.sink                       i_in,
    lrb_out_if.source                    o_out
);

    // one-hot sequencer states
    typedef enum logic [8:0] {
        S_IDLE       = 9'b000000001,
        S_DISPATCH   = 9'b000000010,
        S_HIT_UNLINK = 9'b000000100,
        S_HIT_LINK   = 9'b000001000,
        S_MISS_CHK   = 9'b000010000,
        S_EVICT      = 9'b000100000,
        S_MISS_LOAD  = 9'b001000000,
        S_FL_RD      = 9'b010000000,
        S_FL_EV      = 9'b100000000
    } t_state;

    t_state                              r_state, n_state;
    logic                                r_mode;
    lrb_pkg::t_idx                       r_idx;
    logic [lrb_pkg::SIZE_W-1:0]          r_size;
    logic [lrb_pkg::USED_W-1:0]          r_budget;
    logic [lrb_pkg::NUM_ENTRIES-1:0]     r_flags, n_flags;
    logic [lrb_pkg::CNT_W-1:0]           r_count, n_count;
    logic [lrb_pkg::USED_W-1:0]          r_used, n_used;
    lrb_pkg::t_idx                       r_head, n_head;
    lrb_pkg::t_idx                       r_tail, n_tail;
    logic                                r_ov;
    lrb_pkg::t_out_item                  r_out;

    logic                                in_xfer;
    lrb_pkg::t_idx                       in_idx;
    logic                                rd_en;
    lrb_pkg::t_idx                       rd_addr;
    lrb_pkg::t_wr_cmd                    wr;
    lrb_pkg::t_rd_data                   rd;
    logic                                emit;
    logic                                out_load;
    lrb_pkg::t_out_item                  emit_item;
    lrb_pkg::t_idx                       first_set;
    lrb_pkg::t_idx                       evict_addr;
    logic [lrb_pkg::CNT_W-1:0]           cnt_dec;
    logic [lrb_pkg::USED_W-1:0]          used_dec;
    logic [lrb_pkg::USED_W:0]            used_sum_wide;
    logic [lrb_pkg::USED_W-1:0]          used_add;
    logic                                flushing;

    // ------------------------------------------------------------------
    // channel glue
    // ------------------------------------------------------------------
    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid & i_in.ready;
    assign in_idx     = lrb_pkg::reduce_index(i_in.entry_index);

    // output register loads when empty or when its item transfers this cycle
    assign out_load = emit & (~r_ov | o_out.ready);

    assign o_out.valid        = r_ov;
    assign o_out.event_res    = r_out.event_res;
    assign o_out.result_index = r_out.result_index;
    assign o_out.used_total   = r_out.used_total;
    assign o_out.last         = r_out.last;

    // ------------------------------------------------------------------
    // list store
    // ------------------------------------------------------------------
    lrb_list_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_rd      (rd)
    );

    // lowest resident entry, for the ascending flush order
    always_comb begin
        first_set = '0;
        for (int k = lrb_pkg::NUM_ENTRIES - 1; k >= 0; k--) begin
            if (r_flags[k]) begin
                first_set = lrb_pkg::IDX_W'(k);
            end
        end
    end

    // shared eviction arithmetic: tail on a miss, lowest resident entry on a flush
    assign flushing   = (r_state == S_FL_RD) || (r_state == S_FL_EV);
    assign evict_addr = (r_state == S_FL_EV) ? first_set : r_tail;
    assign cnt_dec    = r_count - lrb_pkg::CNT_W'(1);

    always_comb begin
        // subtract stops at zero, and an empty set always holds zero
        if (r_used >= lrb_pkg::USED_W'(rd.size)) begin
            used_dec = r_used - lrb_pkg::USED_W'(rd.size);
        end else begin
            used_dec = '0;
        end
        if (cnt_dec == '0) begin
            used_dec = '0;
        end
    end

    // load adds the new size, saturating at the top of the range
    assign used_sum_wide = {1'b0, r_used} + (lrb_pkg::USED_W + 1)'(r_size);
    assign used_add      = used_sum_wide[lrb_pkg::USED_W] ? lrb_pkg::USED_MAX
                                                          : used_sum_wide[lrb_pkg::USED_W-1:0];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_flags   = r_flags;
        n_count   = r_count;
        n_used    = r_used;
        n_head    = r_head;
        n_tail    = r_tail;
        rd_en     = 1'b0;
        rd_addr   = r_idx;
        wr        = '0;
        emit      = 1'b0;
        emit_item = '0;

        unique case (r_state)
            S_IDLE: begin
                // read the requested entry's links right away
                if (in_xfer) begin
                    rd_en   = 1'b1;
                    rd_addr = in_idx;
                    n_state = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                if (r_mode) begin
                    n_state = S_FL_RD;
                end else if (r_flags[r_idx]) begin
                    if (r_idx == r_head) begin
                        // already most recent, order unchanged
                        emit      = 1'b1;
                        emit_item = '{lrb_pkg::EV_HIT, lrb_pkg::IN_IDX_W'(r_idx), r_used, 1'b1};
                        if (out_load) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_state = S_HIT_UNLINK;
                    end
                end else begin
                    n_state = S_MISS_CHK;
                end
            end

            S_HIT_UNLINK: begin
                // take the entry out: next of its prev, prev of its next or the tail
                wr.next_we   = 1'b1;
                wr.link_addr = rd.prev;
                wr.next_data = rd.next;
                if (r_idx == r_tail) begin
                    n_tail = rd.prev;
                end else begin
                    wr.prev_we   = 1'b1;
                    wr.prev_addr = rd.next;
                    wr.prev_data = rd.prev;
                end
                n_state = S_HIT_LINK;
            end

            S_HIT_LINK: begin
                // put it in front of the old head
                emit      = 1'b1;
                emit_item = '{lrb_pkg::EV_HIT, lrb_pkg::IN_IDX_W'(r_idx), r_used, 1'b1};
                if (out_load) begin
                    wr.next_we   = 1'b1;
                    wr.link_addr = r_idx;
                    wr.next_data = r_head;
                    wr.prev_we   = 1'b1;
                    wr.prev_addr = r_head;
                    wr.prev_data = r_idx;
                    n_head       = r_idx;
                    n_state      = S_IDLE;
                end
            end

            S_MISS_CHK: begin
                // budget check uses the total before the new size
                if ((r_used > r_budget) && (r_count != '0)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_tail;
                    n_state = S_EVICT;
                end else begin
                    n_state = S_MISS_LOAD;
                end
            end

            S_EVICT: begin
                emit      = 1'b1;
                emit_item = '{lrb_pkg::EV_EVICT, lrb_pkg::IN_IDX_W'(evict_addr), used_dec, 1'b0};
                if (out_load) begin
                    n_flags[evict_addr] = 1'b0;
                    n_count             = cnt_dec;
                    n_used              = used_dec;
                    n_tail              = rd.prev;
                    n_state             = S_MISS_CHK;
                end
            end

            S_MISS_LOAD: begin
                emit      = 1'b1;
                emit_item = '{lrb_pkg::EV_MISS, lrb_pkg::IN_IDX_W'(r_idx), used_add, 1'b1};
                if (out_load) begin
                    wr.next_we   = 1'b1;
                    wr.size_we   = 1'b1;
                    wr.link_addr = r_idx;
                    wr.next_data = r_head;
                    wr.size_data = r_size;
                    if (r_count != '0) begin
                        wr.prev_we   = 1'b1;
                        wr.prev_addr = r_head;
                        wr.prev_data = r_idx;
                    end else begin
                        // empty list: the new entry is also the back
                        n_tail = r_idx;
                    end
                    n_head           = r_idx;
                    n_flags[r_idx]   = 1'b1;
                    n_count          = r_count + lrb_pkg::CNT_W'(1);
                    n_used           = used_add;
                    n_state          = S_IDLE;
                end
            end

            S_FL_RD: begin
                if (|r_flags) begin
                    rd_en   = 1'b1;
                    rd_addr = first_set;
                    n_state = S_FL_EV;
                end else begin
                    emit      = 1'b1;
                    emit_item = '{lrb_pkg::EV_FLUSH, '0, '0, 1'b1};
                    if (out_load) begin
                        n_count = '0;
                        n_used  = '0;
                        n_state = S_IDLE;
                    end
                end
            end

            S_FL_EV: begin
                emit      = 1'b1;
                emit_item = '{lrb_pkg::EV_EVICT, lrb_pkg::IN_IDX_W'(evict_addr), used_dec, 1'b0};
                if (out_load) begin
                    n_flags[evict_addr] = 1'b0;
                    n_count             = cnt_dec;
                    n_used              = used_dec;
                    n_state             = S_FL_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_flags  <= '0;
            r_count  <= '0;
            r_used   <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_budget <= lrb_pkg::BUDGET_RESET;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flags <= n_flags;
            r_count <= n_count;
            r_used  <= n_used;
            r_head  <= n_head;
            r_tail  <= n_tail;
            if (i_cfg_we) begin
                r_budget <= i_cfg_wdata;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode <= i_in.mode;
            r_idx  <= in_idx;
            r_size <= i_in.entry_size;
        end
        if (out_load) begin
            r_out <= emit_item;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `LRB_ASSERT_ALWAYS(a_flag_count, i_clk, i_rst_n, $countones(r_flags) == r_count, "resident bits disagree with count")
    `LRB_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= lrb_pkg::CNT_W'(lrb_pkg::NUM_ENTRIES), "resident count out of range")
    `LRB_ASSERT_IMPLIES(a_empty_used, i_clk, i_rst_n, r_count == '0, r_used == '0, "used total nonzero with nothing resident")
    `LRB_ASSERT_IMPLIES(a_ends_resident, i_clk, i_rst_n, (r_count != '0) && !flushing, r_flags[r_head] && r_flags[r_tail], "list head or tail not resident")
    `LRB_ASSERT_IMPLIES(a_evict_resident, i_clk, i_rst_n, out_load && (emit_item.event_res == lrb_pkg::EV_EVICT), r_flags[evict_addr], "evicting an entry that is not resident")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for lru_residency_size_budget: directed and random lookups and
// flushes under several budgets, with a scoreboard class that predicts every result item
// depends on lrb_pkg, lrb_ifs and the lru_residency_size_budget rtl
module testbench;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 51;

    // scoreboard: own copy of the lru state, predicts the result transfers of each
    // accepted request and checks them in order
    class residency_scoreboard;
        bit                         is_resident[lrb_pkg::NUM_ENTRIES];
        int unsigned                lru_rank[lrb_pkg::NUM_ENTRIES];
        logic [lrb_pkg::SIZE_W-1:0] held_size[lrb_pkg::NUM_ENTRIES];
        int unsigned                resident_n;
        int unsigned                chunk_total;
        logic [lrb_pkg::USED_W-1:0] budget;
        lrb_pkg::t_out_item         owed_results[$];
        int                         mismatches;

        function new();
            foreach (is_resident[i]) begin
                is_resident[i] = 1'b0;
                lru_rank[i]    = 0;
                held_size[i]   = '0;
            end
            resident_n  = 0;
            chunk_total = 0;
            budget      = lrb_pkg::BUDGET_RESET;
            mismatches  = 0;
        endfunction

        function void owe(lrb_pkg::t_event ev, int unsigned idx, int unsigned total, bit lst);
            lrb_pkg::t_out_item r;
            r.event_res    = ev;
            r.result_index = lrb_pkg::IN_IDX_W'(idx);
            r.used_total   = lrb_pkg::USED_W'(total);
            r.last         = lst;
            owed_results.insert(owed_results.size(), r);
        endfunction

        // take one entry out; total never goes below zero and is cleared when empty
        function void drop_entry(int unsigned e);
            is_resident[e] = 1'b0;
            if (resident_n > 0) resident_n--;
            if (chunk_total >= held_size[e]) chunk_total -= held_size[e];
            else chunk_total = 0;
            if (resident_n == 0) chunk_total = 0;
        endfunction

        function void note_request(bit mode, logic [lrb_pkg::IN_IDX_W-1:0] raw_idx,
                                   logic [lrb_pkg::SIZE_W-1:0] size);
            int unsigned idx;
            int unsigned r;
            int          back;
            idx = int'(raw_idx) % lrb_pkg::NUM_ENTRIES;

            // flush: evict in ascending index order, then one completion item
            if (mode) begin
                for (int i = 0; i < lrb_pkg::NUM_ENTRIES; i++) begin
                    if (is_resident[i]) begin
                        drop_entry(i);
                        owe(lrb_pkg::EV_EVICT, i, chunk_total, 1'b0);
                    end
                end
                foreach (lru_rank[i]) lru_rank[i] = 0;
                resident_n  = 0;
                chunk_total = 0;
                owe(lrb_pkg::EV_FLUSH, 0, 0, 1'b1);
                return;
            end

            // hit: move to the front, size input ignored
            if (is_resident[idx]) begin
                r = lru_rank[idx];
                for (int i = 0; i < lrb_pkg::NUM_ENTRIES; i++)
                    if (is_resident[i] && lru_rank[i] < r) lru_rank[i]++;
                lru_rank[idx] = 0;
                owe(lrb_pkg::EV_HIT, idx, chunk_total, 1'b1);
                return;
            end

            // miss: evict from the back while over budget, checked before the new size
            while (chunk_total > budget && resident_n > 0) begin
                back = -1;
                for (int i = 0; i < lrb_pkg::NUM_ENTRIES; i++) begin
                    if (is_resident[i] && lru_rank[i] == resident_n - 1) begin
                        back = i;
                        break;
                    end
                end
                if (back < 0) break;
                drop_entry(back);
                owe(lrb_pkg::EV_EVICT, back, chunk_total, 1'b0);
            end
            for (int i = 0; i < lrb_pkg::NUM_ENTRIES; i++)
                if (is_resident[i]) lru_rank[i]++;
            is_resident[idx] = 1'b1;
            lru_rank[idx]    = 0;
            held_size[idx]   = size;
            resident_n++;
            chunk_total += size;
            if (chunk_total > lrb_pkg::USED_MAX) chunk_total = lrb_pkg::USED_MAX;
            owe(lrb_pkg::EV_MISS, idx, chunk_total, 1'b1);
        endfunction

        function void check_result(lrb_pkg::t_out_item got);
            lrb_pkg::t_out_item want;
            if (owed_results.size() == 0) begin
                $error("result transfer with nothing pending: event_res %0d index %0d",
                       got.event_res, got.result_index);
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            if (got.event_res !== want.event_res) begin
                $error("event_res: expected %0d, got %0d", want.event_res, got.event_res);
                mismatches++;
            end
            if (got.result_index !== want.result_index) begin
                $error("result_index: expected %0d, got %0d",
                       want.result_index, got.result_index);
                mismatches++;
            end
            if (got.used_total !== want.used_total) begin
                $error("used_total: expected %0d, got %0d", want.used_total, got.used_total);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    logic [lrb_pkg::USED_W-1:0] cfg_wdata;

    lrb_in_if  req_if ();
    lrb_out_if res_if ();

    residency_scoreboard board = new();

    int unsigned cycle_count  = 0;
    bit          hold_wanted  = 1'b0;

    // sender pacing: bursts of random length with random gaps, switched off in steady phases
    bit pacing_on   = 1'b1;
    int burst_left  = 0;

    always #2 clk = ~clk;

    lru_residency_size_budget i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (req_if.sink),
        .o_out      (res_if.source)
    );

    // result monitor: every accepted result transfer is checked against the oldest prediction
    always @(posedge clk) begin
        lrb_pkg::t_out_item got;
        if (rst_n && res_if.valid && res_if.ready) begin
            got.event_res    = res_if.event_res;
            got.result_index = res_if.result_index;
            got.used_total   = res_if.used_total;
            got.last         = res_if.last;
            board.check_result(got);
        end
    end

    // one request transfer; optional gap before it, driven at the falling edge
    task automatic offer_request(bit mode, logic [lrb_pkg::IN_IDX_W-1:0] idx,
                                 logic [lrb_pkg::SIZE_W-1:0] size);
        int gap;
        if (pacing_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 12);
                if (gap > 0) begin
                    @(negedge clk);
                    req_if.valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
        end
        @(negedge clk);
        req_if.valid       <= 1'b1;
        req_if.mode        <= mode;
        req_if.entry_index <= idx;
        req_if.entry_size  <= size;
        do @(posedge clk); while (!req_if.ready);
        board.note_request(mode, idx, size);
    endtask

    // stop sending, let every predicted result come out, then write the budget
    task automatic drain_and_set_budget(logic [lrb_pkg::USED_W-1:0] value);
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (board.owed_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        board.budget = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // result side: stall styles change every so often; a long hold-off on request
    initial begin : result_sink
        int style;
        int span;
        res_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(40, 200);
            for (int c = 0; c < span; c++) begin
                @(negedge clk);
                if (hold_wanted) begin
                    // block fills up and has to push back on the request side
                    hold_wanted = 1'b0;
                    res_if.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                end else begin
                    case (style)
                        0: res_if.ready <= 1'b1;
                        1: res_if.ready <= 1'($urandom_range(0, 1));
                        2: res_if.ready <= ($urandom_range(0, 9) != 0);
                        default: res_if.ready <= (c % 4 == 0);
                    endcase
                end
            end
        end
    end

    // watchdog
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    initial begin : stimulus
        logic [lrb_pkg::USED_W-1:0]   phase_budget[8];
        bit                           mode;
        logic [lrb_pkg::IN_IDX_W-1:0] idx;
        logic [lrb_pkg::SIZE_W-1:0]   size;
        int                           ws_base;
        int                           ws_span;

        phase_budget = '{21'd300000, 21'd65535, 21'd0, lrb_pkg::USED_MAX,
                         21'd1, 21'd150000, 21'd1000000, 21'd700000};

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_if.valid       = 1'b0;
        req_if.mode        = 1'b0;
        req_if.entry_index = '0;
        req_if.entry_size  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, budget at its reset value
        offer_request(1'b1, 5'd0, 16'd0);          // flush with nothing resident
        offer_request(1'b0, 5'd0, 16'd0);          // miss, zero size
        offer_request(1'b0, 5'd31, 16'hFFFF);      // miss, largest index and size
        offer_request(1'b0, 5'd31, 16'd123);       // hit on the front entry
        offer_request(1'b0, 5'd0, 16'hFFFF);       // hit further back, size ignored
        offer_request(1'b0, 5'd21, 16'hAAAA);
        offer_request(1'b0, 5'd10, 16'h5555);
        offer_request(1'b0, 5'd31, 16'd7);         // hit on the back entry
        offer_request(1'b1, 5'd17, 16'hFFFF);      // flush, evicts in index order

        // directed, zero budget: every miss evicts from the back until the total is zero
        drain_and_set_budget('0);
        offer_request(1'b0, 5'd5, 16'd100);
        offer_request(1'b0, 5'd6, 16'd7);          // evicts 5
        offer_request(1'b0, 5'd7, 16'd0);          // evicts 6, total back to zero
        offer_request(1'b0, 5'd8, 16'd0);          // total not over budget, no eviction
        offer_request(1'b0, 5'd7, 16'd9);          // hit
        offer_request(1'b0, 5'd9, 16'd1);
        offer_request(1'b0, 5'd3, 16'd2);          // evicts down to an empty set
        offer_request(1'b0, 5'd4, 16'd0);
        offer_request(1'b0, 5'd3, 16'd0);
        offer_request(1'b1, 5'd31, 16'd0);

        // random phases, one budget each
        foreach (phase_budget[p]) begin
            drain_and_set_budget(phase_budget[p]);
            pacing_on = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            ws_base = $urandom_range(0, lrb_pkg::NUM_ENTRIES - 1);
            ws_span = $urandom_range(4, 14);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((p == 1 || p == 4) && n == 10) hold_wanted = 1'b1;
                mode = ($urandom_range(0, 99) < 4);
                if ($urandom_range(0, 99) < 70)
                    idx = lrb_pkg::IN_IDX_W'((ws_base + $urandom_range(0, ws_span - 1))
                                             % lrb_pkg::NUM_ENTRIES);
                else
                    idx = lrb_pkg::IN_IDX_W'($urandom_range(0, 31));
                case ($urandom_range(0, 9))
                    0: size = '0;
                    1: size = '1;
                    2, 3, 4, 5: size = lrb_pkg::SIZE_W'($urandom_range(0, 4000));
                    default: size = lrb_pkg::SIZE_W'($urandom_range(0, 65535));
                endcase
                offer_request(mode, idx, size);
            end
        end

        // wind down: everything owed must arrive, then nothing extra may follow
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (board.owed_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
